### src/bps_pkg.sv
// Package for the byte pattern scanner: payload and control types, register codes, defaults.
// No dependencies; every other file of the block but bps_stream_if imports it.
`default_nettype none

package bps_pkg;

    localparam int DEFAULT_MAX_PATTERN_BYTES = 16;
    localparam int DEFAULT_OFFSET_BITS       = 32;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;
    localparam int LENGTH_BITS    = 5;
    localparam int SPAN_BITS      = 4;   // pattern length minus one, at most 15
    localparam int COUNT_BITS     = 32;
    localparam int REPORT_OFFSET_BITS = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bps_in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         match_count;
        logic [REPORT_OFFSET_BITS-1:0] match_offset;
        logic                          found;
    } bps_out_t;

    // Settled configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] pattern_low;
        logic [CFG_DATA_BITS-1:0] pattern_high;
        logic [SPAN_BITS-1:0]     span;
    } bps_cfg_t;

    // One processing step of the scan datapath
    typedef struct packed {
        logic advance;   // a byte is consumed this cycle
        logic last;      // that byte closes the image
    } bps_step_t;

endpackage

`default_nettype wire

### src/bps_stream_if.sv
// Valid/ready stream interface used for both channels of the byte pattern scanner.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface bps_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/bps_cfg.sv
// Configuration register file: pattern bytes and pattern length, with length clamping.
// Depends on bps_pkg.
`default_nettype none

module bps_cfg
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      write_enable,
    input  wire logic [CFG_INDEX_BITS-1:0] register_index,
    input  wire logic [CFG_DATA_BITS-1:0]  write_data,
    output bps_cfg_t                       cfg
);

    logic [CFG_DATA_BITS-1:0] pattern_low_reg;
    logic [CFG_DATA_BITS-1:0] pattern_high_reg;
    logic [LENGTH_BITS-1:0]   pattern_length_reg;
    logic [LENGTH_BITS-1:0]   eff_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LENGTH_BITS'(1);
        end
        else if (write_enable)
        begin
            unique case (register_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= write_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= write_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= write_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // zero means one byte; anything above the window is clamped to it
    always_comb
    begin
        eff_length = pattern_length_reg;
        if (pattern_length_reg == '0)
            eff_length = LENGTH_BITS'(1);
        else if (pattern_length_reg > LENGTH_BITS'(MAX_PATTERN_BYTES))
            eff_length = LENGTH_BITS'(MAX_PATTERN_BYTES);
    end

    assign cfg.pattern_low  = pattern_low_reg;
    assign cfg.pattern_high = pattern_high_reg;
    assign cfg.span         = SPAN_BITS'(eff_length - LENGTH_BITS'(1));

endmodule

`default_nettype wire

### src/bps_match.sv
// Byte window shift register and parallel pattern compare.
// Depends on bps_pkg.
`default_nettype none

module bps_match
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire bps_step_t  step,
    input  wire logic [7:0] data_byte,
    input  wire bps_cfg_t   cfg,
    output logic            bytes_match
);

    localparam int IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [7:0] window_reg  [MAX_PATTERN_BYTES];
    logic [7:0] window_next [MAX_PATTERN_BYTES];
    logic [7:0] pattern     [MAX_PATTERN_BYTES];
    logic [IDX_BITS-1:0] idx [MAX_PATTERN_BYTES];

    // newest byte at entry 0
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
            window_next[i] = window_reg[i-1];
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            if (k < 8)
                pattern[k] = cfg.pattern_low[8*(k%8) +: 8];
            else
                pattern[k] = cfg.pattern_high[8*(k%8) +: 8];
        end
    end

    // pattern byte k lines up with window entry span-k
    always_comb
    begin
        bytes_match = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            idx[k] = IDX_BITS'(cfg.span - SPAN_BITS'(k));
            if ((SPAN_BITS'(k) <= cfg.span) && (window_next[idx[k]] != pattern[k]))
                bytes_match = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                window_reg[i] <= '0;
        end
        else if (step.advance)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                window_reg[i] <= step.last ? 8'd0 : window_next[i];
        end
    end

endmodule

`default_nettype wire

### src/bps_tally.sv
// Byte position, match count, latest match offset and found flag; builds the report.
// Depends on bps_pkg.
`default_nettype none

module bps_tally
    import bps_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bps_step_t            step,
    input  wire logic                 bytes_match,
    input  wire logic [SPAN_BITS-1:0] span,
    output bps_out_t                  report
);

    localparam int WIDE_BITS = (OFFSET_BITS > REPORT_OFFSET_BITS) ? OFFSET_BITS
                                                                   : REPORT_OFFSET_BITS;

    logic [OFFSET_BITS-1:0] position_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   seen_reg;

    logic                   hit;
    logic [OFFSET_BITS-1:0] position_next;
    logic [COUNT_BITS-1:0]  count_next;
    logic [OFFSET_BITS-1:0] offset_next;
    logic                   seen_next;
    logic [WIDE_BITS-1:0]   offset_wide;

    always_comb
    begin
        // a match needs at least pattern-length bytes of the image behind it
        hit = bytes_match && (position_reg >= OFFSET_BITS'(span));

        count_next  = count_reg;
        offset_next = offset_reg;
        if (hit)
        begin
            if (count_reg != '1)
                count_next = count_reg + COUNT_BITS'(1);
            offset_next = position_reg - OFFSET_BITS'(span);
        end
        seen_next = seen_reg | hit;

        position_next = position_reg;
        if (position_reg != '1)
            position_next = position_reg + OFFSET_BITS'(1);

        offset_wide         = WIDE_BITS'(offset_next);
        report.match_count  = count_next;
        report.match_offset = seen_next ? offset_wide[REPORT_OFFSET_BITS-1:0] : '0;
        report.found        = seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            count_reg    <= '0;
            offset_reg   <= '0;
            seen_reg     <= 1'b0;
        end
        else if (step.advance)
        begin
            if (step.last)
            begin
                position_reg <= '0;
                count_reg    <= '0;
                offset_reg   <= '0;
                seen_reg     <= 1'b0;
            end
            else
            begin
                position_reg <= position_next;
                count_reg    <= count_next;
                offset_reg   <= offset_next;
                seen_reg     <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

### src/byte_pattern_scanner.sv
// Top level of the byte pattern scanner: input register, scan datapath, result register.
// Depends on bps_pkg, bps_stream_if, bps_cfg, bps_match and bps_tally.
`default_nettype none

// Streams a memory image in, one byte per transaction, and counts occurrences of a
// pattern of 1 to MAX_PATTERN_BYTES bytes (overlapping ones included). Each image byte
// is held in the input register while the window compare and the counters update,
// and the byte flagged last_byte loads one report transaction (count, latest start
// offset, found) into the result register, after which the scan state starts afresh.
// Throughput is one byte per clock; only a report still waiting on the output when the
// next last byte arrives stalls the input. The report is offered from the result
// register once the last byte has left the input register, and can be taken at the
// following edge. The pattern registers must only be written while no byte is in
// flight.
module byte_pattern_scanner
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = DEFAULT_OFFSET_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      write_enable,
    input  wire logic [CFG_INDEX_BITS-1:0] register_index,
    input  wire logic [CFG_DATA_BITS-1:0]  write_data,
    bps_stream_if.sink                     image,
    bps_stream_if.source                   report
);

    bps_cfg_t  cfg;
    bps_step_t step;
    bps_out_t  result;
    logic      bytes_match;

    // input register
    logic    in_valid_reg;
    bps_in_t in_item_reg;

    // result register
    logic     out_valid_reg;
    bps_out_t out_item_reg;

    logic fire;

    // A byte in the input register moves on unless it would produce a report and the
    // result register is still occupied by one that is not being taken this cycle.
    assign fire = in_valid_reg &&
                  (!in_item_reg.last_byte || !out_valid_reg || report.ready);

    assign image.ready = !in_valid_reg || fire;

    assign step.advance = fire;
    assign step.last    = in_item_reg.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (image.ready)
            in_valid_reg <= image.valid;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (image.ready && image.valid)
            in_item_reg <= image.payload;
    end

    bps_cfg #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data),
        .cfg            (cfg)
    );

    bps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_item_reg.data_byte),
        .cfg         (cfg),
        .bytes_match (bytes_match)
    );

    bps_tally #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .bytes_match (bytes_match),
        .span        (cfg.span),
        .report      (result)
    );

    // Result register: loaded by the last byte, emptied when the report transaction
    // completes. A new load in the same cycle as a take simply replaces it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && in_item_reg.last_byte)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_item_reg.last_byte)
            out_item_reg <= result;
    end

    assign report.valid   = out_valid_reg;
    assign report.payload = out_item_reg;

endmodule

`default_nettype wire

### dv/tb_byte_pattern_scanner.sv
// Self-checking bench for byte_pattern_scanner: directed and random memory images are
// streamed in, and every report transaction is checked against a local scan predictor.
// Depends on bps_pkg, bps_stream_if and byte_pattern_scanner from the RTL.
module tb_byte_pattern_scanner;
    import bps_pkg::*;

    localparam int WINDOW_BYTES  = DEFAULT_MAX_PATTERN_BYTES;
    localparam int MAX_GAP       = 14;
    localparam int HOLD_CYCLES   = 120;   // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYCLES = 6;     // settle time after the last report, with margin
    localparam int STALL_LIMIT   = 3000;  // cycles with no transaction on either side
    localparam int TARGET_BYTES  = 1300;

    // Index 3 decodes to no register; writes to it must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [31:0]               POSITION_TOP    = 32'hFFFF_FFFF;
    localparam logic [COUNT_BITS-1:0]     COUNT_TOP       = '1;

    typedef enum {PAT_RANDOM, PAT_REPEATED, PAT_TWO_VALUE} pattern_style_t;
    typedef enum {IMG_PLANTED, IMG_NOISE} image_kind_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Channel drive, kept in bench variables so both channels are known from time zero
    logic    feed_valid = 1'b0;
    bps_in_t feed_item  = '0;
    logic    take_ready = 1'b0;

    // Pacing controls, written only by the stimulus process at a falling edge
    logic calm     = 1'b0;   // no idling on either side
    logic hold_req = 1'b0;   // ask the receiver for its one long hold-off

    bps_stream_if #(.payload_t(bps_in_t))  image_if ();
    bps_stream_if #(.payload_t(bps_out_t)) report_if ();

    assign image_if.valid   = feed_valid;
    assign image_if.payload = feed_item;
    assign report_if.ready  = take_ready;

    byte_pattern_scanner u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_enable   (cfg_we),
        .register_index (cfg_index),
        .write_data     (cfg_data),
        .image          (image_if),
        .report         (report_if)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scan predictor: mirror of the registers and of the scan state
    // ------------------------------------------------------------------
    logic [CFG_DATA_BITS-1:0] pat_low_m  = '0;
    logic [CFG_DATA_BITS-1:0] pat_high_m = '0;
    logic [LENGTH_BITS-1:0]   pat_len_m  = 5'd1;

    logic [7:0]            window_m [WINDOW_BYTES];   // newest byte at index 0
    logic [31:0]           position_m;                // offset of the next byte
    logic [COUNT_BITS-1:0] hits_m;
    logic [31:0]           latest_m;
    logic                  seen_m;

    bps_out_t    expected_reports [$];
    bps_in_t     pending_bytes [$];
    logic [7:0]  image_bytes [$];
    int unsigned loaded_bytes = 0;
    int unsigned error_count  = 0;

    function automatic logic [7:0] pattern_at(int unsigned k);
        if (k < 8)
            return pat_low_m[8*k +: 8];
        return pat_high_m[8*(k-8) +: 8];
    endfunction

    // Length as the datapath uses it: zero reads as one, anything past the window clamps
    function automatic int unsigned span_now();
        int unsigned n;
        n = pat_len_m;
        if (n == 0)
            n = 1;
        if (n > WINDOW_BYTES)
            n = WINDOW_BYTES;
        return n;
    endfunction

    function automatic void clear_scan_state();
        foreach (window_m[i])
            window_m[i] = 8'h00;
        position_m = '0;
        hits_m     = '0;
        latest_m   = '0;
        seen_m     = 1'b0;
    endfunction

    // One accepted image byte; queues the report when the byte closes the image
    function automatic void scan_byte(bps_in_t t);
        int unsigned n;
        int          i;
        logic        hit;
        bps_out_t    r;
        n = span_now();
        for (i = WINDOW_BYTES - 1; i > 0; i--)
            window_m[i] = window_m[i-1];
        window_m[0] = t.data_byte;
        // too few image bytes in the window yet: stale zeros must never match
        hit = (position_m >= n - 1);
        for (i = 0; i < n; i++)
            if (window_m[n-1-i] != pattern_at(i))
                hit = 1'b0;
        if (hit)
        begin
            if (hits_m != COUNT_TOP)
                hits_m++;
            latest_m = position_m - (n - 1);
            seen_m   = 1'b1;
        end
        if (position_m != POSITION_TOP)
            position_m++;
        if (t.last_byte)
        begin
            r.match_count  = hits_m;
            r.match_offset = seen_m ? latest_m : '0;
            r.found        = seen_m;
            expected_reports.push_back(r);
            clear_scan_state();
        end
    endfunction

    function automatic void check_report(bps_out_t got);
        bps_out_t want;
        if (expected_reports.size() == 0)
        begin
            $display("%0t: unexpected report, count %0d offset %0d found %0b",
                     $time, got.match_count, got.match_offset, got.found);
            error_count++;
            return;
        end
        want = expected_reports.pop_front();
        if (got.match_count !== want.match_count)
        begin
            $display("%0t: match_count expected %0d, got %0d",
                     $time, want.match_count, got.match_count);
            error_count++;
        end
        if (got.match_offset !== want.match_offset)
        begin
            $display("%0t: match_offset expected %0d, got %0d",
                     $time, want.match_offset, got.match_offset);
            error_count++;
        end
        if (got.found !== want.found)
        begin
            $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Image driver: pops pending bytes, random gap after each transaction
    // ------------------------------------------------------------------
    int unsigned send_wait;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            feed_valid <= 1'b0;
            feed_item  <= '0;
            send_wait  <= 0;
        end
        else
        begin
            if (feed_valid && image_if.ready)
                scan_byte(feed_item);
            // a held byte stays put until taken; the gap only starts once it has gone
            if (!feed_valid || image_if.ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait  <= send_wait - 1;
                    feed_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    feed_item  <= pending_bytes.pop_front();
                    feed_valid <= 1'b1;
                    send_wait  <= calm ? 0 : $urandom_range(0, MAX_GAP);
                end
                else
                    feed_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Report monitor and receiver pacing
    // ------------------------------------------------------------------
    int unsigned take_wait;
    int unsigned take_next;
    int unsigned hold_left;
    logic        hold_taken;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            take_wait  <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            if (report_if.valid && take_ready)
                check_report(report_if.payload);
            if (hold_left != 0)
            begin
                hold_left  <= hold_left - 1;
                take_ready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                // one long back-pressure window, counted here, while images keep coming
                hold_left  <= HOLD_CYCLES;
                hold_taken <= 1'b1;
                take_ready <= 1'b0;
            end
            else
            begin
                if (report_if.valid && take_ready)
                    take_next = calm ? 0 : $urandom_range(0, MAX_GAP);
                else if (take_wait != 0)
                    take_next = take_wait - 1;
                else
                    take_next = 0;
                take_wait  <= take_next;
                take_ready <= (take_next == 0);
            end
        end
    end

    // Watchdog: a run that stops moving is a failure
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (feed_valid && image_if.ready) || (report_if.valid && take_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_LOW:    pat_low_m  = value;
            CFG_PATTERN_HIGH:   pat_high_m = value;
            CFG_PATTERN_LENGTH: pat_len_m  = value[LENGTH_BITS-1:0];
            default: ;
        endcase
    endtask

    // Wait for the sender to empty and every report to come back, then let the pipe settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || feed_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hand the assembled image to the driver, last flag on its final byte
    task automatic flush_image();
        bps_in_t t;
        @(negedge clk);
        foreach (image_bytes[k])
        begin
            t.data_byte = image_bytes[k];
            t.last_byte = (k == image_bytes.size() - 1);
            pending_bytes.push_back(t);
        end
        loaded_bytes += image_bytes.size();
        image_bytes.delete();
    endtask

    // Random pattern; the length field goes in with random upper bits
    task automatic program_pattern(int unsigned length_code, pattern_style_t style);
        logic [127:0]             bytes;
        logic [7:0]               a;
        logic [7:0]               b;
        logic [CFG_DATA_BITS-1:0] len_word;
        a = 8'($urandom);
        b = 8'($urandom);
        for (int k = 0; k < WINDOW_BYTES; k++)
            case (style)
                PAT_RANDOM:   bytes[8*k +: 8] = 8'($urandom);
                PAT_REPEATED: bytes[8*k +: 8] = a;   // every shift overlaps
                default:      bytes[8*k +: 8] = $urandom_range(0, 1) ? a : b;
            endcase
        write_register(CFG_PATTERN_LOW, bytes[63:0]);
        write_register(CFG_PATTERN_HIGH, bytes[127:64]);
        len_word = {$urandom, $urandom};
        len_word[LENGTH_BITS-1:0] = LENGTH_BITS'(length_code);
        write_register(CFG_PATTERN_LENGTH, len_word);
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_SPARE_INDEX, {$urandom, $urandom});
    endtask

    // Planted images carry whole copies, copies with one corrupted byte, and pattern and
    // random bytes as filler, so near misses and overlaps are common; noise is plain random.
    task automatic load_image(int unsigned nbytes, image_kind_t kind);
        int unsigned n;
        int unsigned sel;
        int unsigned room;
        int unsigned flip;
        logic [7:0]  v;
        n = span_now();
        while (image_bytes.size() < nbytes)
        begin
            sel  = (kind == IMG_NOISE) ? 9 : $urandom_range(0, 9);
            room = nbytes - image_bytes.size();
            if (sel < 4 && room >= n)
                for (int k = 0; k < n; k++)
                    image_bytes.push_back(pattern_at(k));
            else if (sel < 6 && room >= n)
            begin
                flip = $urandom_range(0, n - 1);
                for (int k = 0; k < n; k++)
                begin
                    v = pattern_at(k);
                    if (k == flip)
                        v = v ^ 8'($urandom_range(1, 255));
                    image_bytes.push_back(v);
                end
            end
            else if (sel < 8)
                image_bytes.push_back(pattern_at($urandom_range(0, n - 1)));
            else
                image_bytes.push_back(8'($urandom));
        end
        flush_image();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int unsigned phase;
    int unsigned len_code;
    int unsigned img_len;

    initial
    begin
        clear_scan_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one-byte pattern 0x00; a single-byte image matches at offset 0
        image_bytes.push_back(8'h00);
        flush_image();
        wait_idle();

        // Length zero behaves as one
        write_register(CFG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
        write_register(CFG_PATTERN_LENGTH, '0);
        image_bytes.push_back(8'hFF);
        image_bytes.push_back(8'hFF);
        flush_image();
        wait_idle();

        // Overlapping matches each count
        write_register(CFG_PATTERN_LOW, 64'h0000_0000_0000_AAAA);
        write_register(CFG_PATTERN_LENGTH, 64'd2);
        repeat (3) image_bytes.push_back(8'hAA);
        flush_image();
        wait_idle();

        // All-zero pattern longer than the image: the cleared window must not match.
        // The spare index write would turn this into a hit if it reached the length.
        write_register(CFG_PATTERN_LOW, '0);
        write_register(CFG_PATTERN_HIGH, '0);
        write_register(CFG_PATTERN_LENGTH, 64'd4);
        write_register(CFG_SPARE_INDEX, 64'd1);
        image_bytes.push_back(8'h00);
        image_bytes.push_back(8'h00);
        flush_image();
        wait_idle();

        // Length field beyond the window clamps to a full sixteen-byte pattern
        write_register(CFG_PATTERN_LOW, 64'h7F80_C33C_A55A_FF00);
        write_register(CFG_PATTERN_HIGH, 64'h0123_4567_89AB_CDEF);
        write_register(CFG_PATTERN_LENGTH, 64'd31);
        for (int k = 0; k < WINDOW_BYTES; k++)
            image_bytes.push_back(pattern_at(k));
        flush_image();

        // Random phases; each starts from an idle block with a fresh pattern
        phase = 0;
        while (loaded_bytes < TARGET_BYTES)
        begin
            wait_idle();
            case (phase % 6)
                0:       len_code = 1;
                1:       len_code = WINDOW_BYTES;
                2:       len_code = 0;
                3:       len_code = $urandom_range(WINDOW_BYTES + 1, 31);
                default: len_code = $urandom_range(1, WINDOW_BYTES);
            endcase
            program_pattern(len_code, pattern_style_t'($urandom_range(0, 2)));
            @(negedge clk);
            calm = (phase % 4 == 1);
            if (phase == 2)
            begin
                // back-pressure phase: short images offered flat out into a stalled output
                calm     = 1'b1;
                hold_req = 1'b1;
                repeat (30) load_image($urandom_range(1, 3), IMG_PLANTED);
            end
            else
                repeat ($urandom_range(4, 10))
                begin
                    img_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                                          : $urandom_range(1, 40);
                    load_image(img_len, ($urandom_range(0, 6) == 0) ? IMG_NOISE
                                                                    : IMG_PLANTED);
                end
            phase++;
        end

        wait_idle();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
src/bps_pkg.sv
src/bps_stream_if.sv
src/bps_cfg.sv
src/bps_match.sv
src/bps_tally.sv
src/byte_pattern_scanner.sv
dv/tb_byte_pattern_scanner.sv
